/* hw/rtl/htbd_pkg.sv */
`timescale 1ns / 1ps

package htbd_pkg;

	localparam int unsigned NODE_COUNT_DEF = 256;
	localparam int unsigned IDX_W          = 8;
	localparam int unsigned SYM_W          = 8;
	localparam int unsigned S_TDATA_W      = 40;
	localparam int unsigned M_TDATA_W      = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	localparam logic STAT_SYMBOL  = 1'b0;
	localparam logic STAT_MISSING = 1'b1;

	typedef struct packed {
		logic [IDX_W-1:0] left;
		logic [IDX_W-1:0] right;
		logic             has_left;
		logic             has_right;
		logic [SYM_W-1:0] symbol;
	} node_t;

	// slave tdata layout, last member holds the lowest bits
	typedef struct packed {
		logic [4:0]       pad;
		logic             code_bit;
		logic [SYM_W-1:0] leaf_symbol;
		logic             has_right;
		logic             has_left;
		logic [IDX_W-1:0] right_child;
		logic [IDX_W-1:0] left_child;
		logic [IDX_W-1:0] node_index;
	} in_data_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		node_t            entry;
	} node_wr_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
	} node_rd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_STEP,
		ST_EMIT
	} htbd_state_t;

	function automatic logic idx_in_range(input logic [IDX_W-1:0] idx, input int unsigned count);
		logic [31:0] wide;
		wide = 32'(idx);
		return wide < count;
	endfunction

endpackage

/* hw/rtl/htbd_node_ram.sv */
`timescale 1ns / 1ps

module htbd_node_ram #(
	parameter int unsigned NODE_COUNT = htbd_pkg::NODE_COUNT_DEF
) (
	input  logic               clk,
	input  htbd_pkg::node_wr_t wr,
	input  htbd_pkg::node_rd_t rd,
	output htbd_pkg::node_t    rd_entry
);
	import htbd_pkg::*;

	localparam int unsigned AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

	node_t       mem [NODE_COUNT];
	node_t       rd_data_s1;
	logic        rd_oor_s1;
	logic [31:0] waddr_wide;
	logic [31:0] raddr_wide;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;

	assign waddr_wide = 32'(wr.idx);
	assign raddr_wide = 32'(rd.idx);
	assign waddr      = waddr_wide[AW-1:0];
	assign raddr      = raddr_wide[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr.en && idx_in_range(wr.idx, NODE_COUNT)) begin
			mem[waddr] <= wr.entry;
		end
	end

	// entries past the table read as an all-zero leaf
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_s1 <= mem[raddr];
			rd_oor_s1  <= !idx_in_range(rd.idx, NODE_COUNT);
		end
	end

	assign rd_entry = rd_oor_s1 ? node_t'('0) : rd_data_s1;

endmodule

/* hw/rtl/huffman_tree_bit_decoder.sv */
`timescale 1ns / 1ps
// channel  | ports                          | payload
// ---------+--------------------------------+---------------------------------------------
// s (in)   | s_tvalid s_tready s_tdata      | tuser: opcode; tdata: node_index left_child
//          | s_tuser                        |   right_child has_left has_right leaf_symbol
//          |                                |   code_bit
// m (out)  | m_tvalid m_tready m_tdata      | tdata: symbol; tuser: status
//          | m_tuser                        |
// cfg      | cfg_we cfg_wdata               | root_index
//
// a load transaction is written from ST_IDLE; a decode bit uses the cached current entry
// in ST_IDLE and ends in ST_STEP after the child lookup, going through ST_FETCH first
// when the entry must be read (after reset, a root write, or a return to a root whose
// entry is not cached yet); a missing child skips ST_STEP, as no child lookup follows; the
// single table read port is used once per lookup; its registered read data sets the pace.
// reset clears the walk to node 0 and drops both entry caches.
// a result waits in the output register; a second result stalls the walk until it drains.

module huffman_tree_bit_decoder #(
	parameter int unsigned NODE_COUNT = htbd_pkg::NODE_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [htbd_pkg::S_TDATA_W-1:0]    s_tdata,   // node_index, left_child, right_child,
	                                                     // has_left, has_right, leaf_symbol,
	                                                     // code_bit, zero pad
	input  logic                              s_tuser,   // opcode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [htbd_pkg::M_TDATA_W-1:0]    m_tdata,   // symbol
	output logic                              m_tuser,   // status
	input  logic                              cfg_we,
	input  logic [htbd_pkg::IDX_W-1:0]        cfg_wdata  // root_index
);
	import htbd_pkg::*;

	htbd_state_t      state_q, state_d;
	in_data_t         in_d;
	node_wr_t         wr_req;
	node_rd_t         rd_req;
	node_t            rd_entry;

	logic [IDX_W-1:0] root_q;
	logic [IDX_W-1:0] cur_idx_q;
	node_t            cur_entry_q;
	logic             cur_vld_q;
	node_t            root_entry_q;
	logic             root_vld_q;
	logic             bit_q;
	logic [IDX_W-1:0] child_q;
	logic [SYM_W-1:0] res_sym_q;
	logic             res_stat_q;
	logic             out_valid_q;
	logic [SYM_W-1:0] out_sym_q;
	logic             out_stat_q;

	logic             s_accept;
	logic             out_free;
	node_t            here;
	logic             bit_v;
	logic             missing;
	logic [IDX_W-1:0] child;
	logic             eval;
	logic             emit;
	logic [SYM_W-1:0] emit_sym;
	logic             emit_stat;
	logic             go_root;
	logic             advance;
	logic             fetch_done;
	logic             load_cur;
	logic             load_root;
	logic             leaf;

	assign in_d     = in_data_t'(s_tdata);
	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	assign here    = (state_q == ST_FETCH) ? rd_entry : cur_entry_q;
	assign bit_v   = (state_q == ST_FETCH) ? bit_q : in_d.code_bit;
	assign missing = bit_v ? !here.has_right : !here.has_left;
	assign child   = bit_v ? here.right : here.left;
	assign leaf    = !rd_entry.has_left && !rd_entry.has_right;

	assign fetch_done = (state_q == ST_FETCH);
	assign load_cur   = wr_req.en && idx_in_range(wr_req.idx, NODE_COUNT)
	                    && (wr_req.idx == cur_idx_q);
	assign load_root  = wr_req.en && idx_in_range(wr_req.idx, NODE_COUNT)
	                    && (wr_req.idx == root_q);

	always_comb begin
		state_d   = state_q;
		rd_req    = '0;
		wr_req    = '0;
		eval      = 1'b0;
		emit      = 1'b0;
		emit_sym  = '0;
		emit_stat = STAT_SYMBOL;
		go_root   = 1'b0;
		advance   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_accept) begin
					if (s_tuser == OP_LOAD) begin
						wr_req.en              = 1'b1;
						wr_req.idx             = in_d.node_index;
						wr_req.entry.left      = in_d.left_child;
						wr_req.entry.right     = in_d.right_child;
						wr_req.entry.has_left  = in_d.has_left;
						wr_req.entry.has_right = in_d.has_right;
						wr_req.entry.symbol    = in_d.leaf_symbol;
					end else if (cur_vld_q) begin
						eval = 1'b1;
					end else begin
						rd_req.en  = 1'b1;
						rd_req.idx = cur_idx_q;
						state_d    = ST_FETCH;
					end
				end
			end
			ST_FETCH: begin
				eval = 1'b1;
			end
			ST_STEP: begin
				state_d = ST_IDLE;
				if (leaf) begin
					emit     = 1'b1;
					emit_sym = rd_entry.symbol;
					go_root  = 1'b1;
				end else begin
					advance = 1'b1;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (eval) begin
			if (missing) begin
				emit      = 1'b1;
				emit_stat = STAT_MISSING;
				go_root   = 1'b1;
			end else begin
				rd_req.en  = 1'b1;
				rd_req.idx = child;
				state_d    = ST_STEP;
			end
		end

		if (emit) begin
			state_d = out_free ? ST_IDLE : ST_EMIT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			root_q      <= '0;
			cur_idx_q   <= '0;
			cur_vld_q   <= 1'b0;
			root_vld_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				root_q     <= cfg_wdata;
				cur_idx_q  <= cfg_wdata;
				cur_vld_q  <= 1'b0;
				root_vld_q <= 1'b0;
			end else begin
				if (load_root) begin
					root_vld_q <= 1'b1;
				end else if ((fetch_done && cur_idx_q == root_q)
				             || (advance && child_q == root_q)) begin
					root_vld_q <= 1'b1;
				end

				if (go_root) begin
					cur_idx_q <= root_q;
					cur_vld_q <= root_vld_q;
				end else if (advance) begin
					cur_idx_q <= child_q;
					cur_vld_q <= 1'b1;
				end else if (fetch_done || load_cur) begin
					cur_vld_q <= 1'b1;
				end
			end

			if (emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_q == ST_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			bit_q <= in_d.code_bit;
		end
		if (eval && !missing) begin
			child_q <= child;
		end

		if (load_root) begin
			root_entry_q <= wr_req.entry;
		end else if (fetch_done && cur_idx_q == root_q) begin
			root_entry_q <= rd_entry;
		end else if (advance && child_q == root_q) begin
			root_entry_q <= rd_entry;
		end

		if (go_root) begin
			cur_entry_q <= root_entry_q;
		end else if (advance || fetch_done) begin
			cur_entry_q <= rd_entry;
		end else if (load_cur) begin
			cur_entry_q <= wr_req.entry;
		end

		if (emit && !out_free) begin
			res_sym_q  <= emit_sym;
			res_stat_q <= emit_stat;
		end

		if (emit && out_free) begin
			out_sym_q  <= emit_sym;
			out_stat_q <= emit_stat;
		end else if (state_q == ST_EMIT && out_free) begin
			out_sym_q  <= res_sym_q;
			out_stat_q <= res_stat_q;
		end
	end

	htbd_node_ram #(
		.NODE_COUNT(NODE_COUNT)
	) u_node_ram (
		.clk     (clk),
		.wr      (wr_req),
		.rd      (rd_req),
		.rd_entry(rd_entry)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sym_q;
	assign m_tuser  = out_stat_q;

endmodule

/* hw/rtl/htbd_checker.sv */
`timescale 1ns / 1ps

module htbd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [htbd_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser
);
	import htbd_pkg::*;

	// a stalled result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// a missing-child result carries a zero symbol
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_MISSING |-> m_tdata == '0)
		else $error("missing-child result with nonzero symbol");

	// a load transaction finishes in its own cycle
	a_load_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == OP_LOAD |=> s_tready)
		else $error("input not ready after a load");

	// a new result follows a decode transaction or a busy walk
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready || (s_tvalid && s_tuser == OP_DECODE)))
		else $error("result without a decode");

endmodule

bind huffman_tree_bit_decoder htbd_checker u_htbd_checker (.*);

/* bench/huffman_tree_bit_decoder_tb.sv */
`timescale 1ns / 1ps

module huffman_tree_bit_decoder_tb;

	import htbd_pkg::*;

	localparam int CLK_HALF       = 6;
	localparam int SETTLE_CYCLES  = 16;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int RANDOM_PHASES  = 5;
	localparam int PHASE_ITEMS    = 200;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             status;
	} decoded_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;   // node_index, left_child, right_child, has_left,
	                                 // has_right, leaf_symbol, code_bit, zero pad
	logic                 s_tuser;   // opcode
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;   // symbol
	logic                 m_tuser;   // status
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_wdata;

	// shadow of the decoder state
	node_t            tree_tbl [NODE_COUNT_DEF];
	bit               node_written [NODE_COUNT_DEF];
	logic [IDX_W-1:0] walk_node;
	logic [IDX_W-1:0] root_sel;
	decoded_t         symbol_q [$];

	int  fail_count;
	int  idle_cycles;
	int  hold_req;
	int  hold_left;
	int  stall_left;
	bit  tx_steady;
	bit  rx_steady;
	decoded_t want;

	huffman_tree_bit_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	task report_mismatch(input string what, input logic [7:0] got, input logic [7:0] exp);
		$display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, exp);
		fail_count++;
	endtask

	// walk the shadow tree for one accepted transaction
	function void track_item(input logic op, input in_data_t d);
		node_t            here;
		node_t            nxt;
		logic [IDX_W-1:0] next_idx;
		if (op == OP_LOAD) begin
			tree_tbl[d.node_index] = '{left: d.left_child, right: d.right_child,
				has_left: d.has_left, has_right: d.has_right, symbol: d.leaf_symbol};
			node_written[d.node_index] = 1'b1;
			return;
		end
		here = tree_tbl[walk_node];
		if (d.code_bit ? !here.has_right : !here.has_left) begin
			symbol_q.push_back('{symbol: '0, status: STAT_MISSING});
			walk_node = root_sel;
			return;
		end
		next_idx = d.code_bit ? here.right : here.left;
		nxt = tree_tbl[next_idx];
		if (!nxt.has_left && !nxt.has_right) begin
			symbol_q.push_back('{symbol: nxt.symbol, status: STAT_SYMBOL});
			walk_node = root_sel;
		end else begin
			walk_node = next_idx;
		end
	endfunction

	function int pick_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// called in the time step of the previous acceptance or of an idle edge
	task send_item(input logic op, input in_data_t d);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		track_item(op, d);
	endtask

	function in_data_t random_fields();
		logic [63:0] r;
		in_data_t    d;
		r = {$urandom, $urandom};
		d = r[S_TDATA_W-1:0];
		d.pad = '0;
		return d;
	endfunction

	task send_load(input logic [7:0] idx, input logic hl, input logic [7:0] l,
		input logic hr, input logic [7:0] r, input logic [7:0] sym);
		in_data_t d;
		d = random_fields();
		d.node_index  = idx;
		d.has_left    = hl;
		d.left_child  = l;
		d.has_right   = hr;
		d.right_child = r;
		d.leaf_symbol = sym;
		send_item(OP_LOAD, d);
	endtask

	task send_bit(input logic b);
		in_data_t d;
		d = random_fields();
		d.code_bit = b;
		send_item(OP_DECODE, d);
	endtask

	task wait_drained();
		s_tvalid <= 1'b0;
		while (symbol_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task set_root(input logic [IDX_W-1:0] v);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		root_sel  = v;
		walk_node = v;
		@(posedge clk);
	endtask

	// children always sit at a higher index than their parent, so the tree has no loops
	// and every referenced child has been written
	function int pick_child(input int idx);
		int cand [$];
		for (int j = idx + 1; j < NODE_COUNT_DEF; j++)
			if (node_written[j])
				cand.push_back(j);
		if (cand.size() == 0)
			return -1;
		return cand[$urandom_range(0, cand.size() - 1)];
	endfunction

	task send_random_load(input int idx, input bit inner);
		int  lc;
		int  rc;
		int  shape;
		logic hl;
		logic hr;
		lc = pick_child(idx);
		rc = pick_child(idx);
		shape = $urandom_range(0, 9);
		hl = inner && lc >= 0 && shape < 8;
		hr = inner && rc >= 0 && (shape < 6 || shape >= 8);
		send_load(idx[7:0], hl, hl ? lc[7:0] : 8'($urandom), hr, hr ? rc[7:0] : 8'($urandom),
			8'($urandom));
	endtask

	// mostly follow existing children so walks reach leaves
	function logic steer_bit();
		node_t here;
		here = tree_tbl[walk_node];
		if (here.has_left && here.has_right)
			return 1'($urandom_range(0, 1));
		if (here.has_left)
			return ($urandom_range(0, 99) < 85) ? 1'b0 : 1'b1;
		if (here.has_right)
			return ($urandom_range(0, 99) < 85) ? 1'b1 : 1'b0;
		return 1'($urandom_range(0, 1));
	endfunction

	task test_tree_walk();
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		set_root(8'd0);
		send_load(8'd10, 1'b0, 8'hff, 1'b0, 8'hff, 8'hff);
		send_load(8'd13, 1'b0, 8'h00, 1'b0, 8'h00, 8'h00);
		send_load(8'd255, 1'b0, 8'h5a, 1'b0, 8'ha5, 8'ha5);
		send_load(8'd12, 1'b1, 8'd13, 1'b0, 8'hff, 8'h3c);
		send_load(8'd0, 1'b1, 8'd10, 1'b1, 8'd12, 8'h77);
		send_bit(1'b0);
		send_bit(1'b1);
		send_bit(1'b1);   // right child missing
		send_bit(1'b1);
		send_bit(1'b0);
		// a load in mid walk leaves the walk in place
		send_bit(1'b1);
		send_load(8'd200, 1'b0, 8'h12, 1'b0, 8'h34, 8'hc3);
		send_bit(1'b0);
		wait_drained();
	endtask

	task test_root_select();
		set_root(8'd255);
		send_bit(1'b0);   // leaf at the root has no children
		send_bit(1'b1);
		set_root(8'd0);
		send_bit(1'b1);
		// rewriting the root pulls the walk back
		set_root(8'd0);
		send_bit(1'b0);
		wait_drained();
	endtask

	task test_node_rewrite();
		set_root(8'd0);
		send_bit(1'b1);
		send_load(8'd12, 1'b0, 8'h00, 1'b0, 8'h00, 8'h99);
		send_bit(1'b0);
		send_load(8'd12, 1'b1, 8'd13, 1'b0, 8'h00, 8'h3c);
		send_bit(1'b1);
		send_bit(1'b0);
		wait_drained();
	endtask

	task test_backpressure();
		set_root(8'd0);
		tx_steady = 1'b1;
		hold_req  = 300;
		for (int i = 0; i < 40; i++)
			send_bit(1'b0);
		wait_drained();
		tx_steady = 1'b0;
	endtask

	task test_random_streams();
		int idx;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			tx_steady = (p == 2);
			rx_steady = (p == 2);
			wait_drained();
			idx = $urandom_range(0, 63);
			send_random_load(idx, 1'b1);
			set_root(idx[7:0]);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 30) begin
					if ($urandom_range(0, 1))
						idx = $urandom_range(0, NODE_COUNT_DEF - 1);
					else
						do idx = $urandom_range(0, NODE_COUNT_DEF - 1); while (!node_written[idx]);
					send_random_load(idx, $urandom_range(0, 99) < 55);
				end else begin
					send_bit(steer_bit());
				end
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		wait_drained();
	endtask

	// result side: random stalls plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_req > 0) begin
			hold_left = hold_req;
			hold_req  = 0;
		end
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (!rx_steady && $urandom_range(0, 99) < 30) begin
			stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2) : $urandom_range(8, 40);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (symbol_q.size() == 0) begin
				report_mismatch("unexpected result transaction", m_tdata, 8'h00);
			end else begin
				want = symbol_q.pop_front();
				if (m_tuser !== want.status)
					report_mismatch("status", 8'(m_tuser), 8'(want.status));
				if (m_tdata !== want.symbol)
					report_mismatch("symbol", m_tdata, want.symbol);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("huffman_tree_bit_decoder verification failed");
			$finish;
		end
	end

	initial begin
		fail_count  = 0;
		idle_cycles = 0;
		hold_req    = 0;
		hold_left   = 0;
		stall_left  = 0;
		tx_steady   = 1'b0;
		rx_steady   = 1'b0;
		walk_node   = '0;
		root_sel    = '0;
		foreach (node_written[i]) begin
			node_written[i] = 1'b0;
			tree_tbl[i]     = '0;
		end
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= OP_LOAD;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tree_walk();
		test_root_select();
		test_node_rewrite();
		test_backpressure();
		test_random_streams();

		wait_drained();
		if (fail_count == 0 && symbol_q.size() == 0)
			$display("huffman_tree_bit_decoder verification clean");
		else
			$display("huffman_tree_bit_decoder verification failed");
		$finish;
	end

endmodule
